### hw/rtl/mts_pkg.sv
// Shared constants and control types for the min-tracking stack.
package mts_pkg;

    localparam int DEF_STACK_DEPTH = 64;
    localparam int DEF_VALUE_WIDTH = 32;

    localparam int ACTION_W      = 2;
    localparam int STATUS_W      = 2;
    localparam int DEPTH_FIELD_W = 7;

    localparam logic [ACTION_W-1:0] ACT_QUERY = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_PUSH  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_POP   = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;

    // Shift command broadcast to every cell of the chain.
    typedef struct packed {
        logic push;   // every cell takes its upper neighbor
        logic pop;    // every cell takes its lower neighbor
    } shift_ctrl_t;

endpackage

### hw/rtl/mts_cell.sv
// One stack cell: an entry and the running minimum at and below it.
module mts_cell
    import mts_pkg::*;
#(
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
    input  logic                          aclk,
    input  shift_ctrl_t                   ctrl,
    input  logic signed [VALUE_WIDTH-1:0] up_data,
    input  logic signed [VALUE_WIDTH-1:0] up_min,
    input  logic signed [VALUE_WIDTH-1:0] dn_data,
    input  logic signed [VALUE_WIDTH-1:0] dn_min,
    output logic signed [VALUE_WIDTH-1:0] data_q,
    output logic signed [VALUE_WIDTH-1:0] min_q
);

    logic signed [VALUE_WIDTH-1:0] data_reg;
    logic signed [VALUE_WIDTH-1:0] min_reg;

    // payload only, no reset: entries beyond the count are never shown
    always_ff @(posedge aclk) begin
        if (ctrl.push) begin
            data_reg <= up_data;
            min_reg  <= up_min;
        end else if (ctrl.pop) begin
            data_reg <= dn_data;
            min_reg  <= dn_min;
        end
    end

    assign data_q = data_reg;
    assign min_q  = min_reg;

endmodule

### hw/rtl/min_tracking_stack_core.sv
// Top level of the min-tracking stack: cell chain, entry count and result register.
//
// A LIFO stack of signed values that also reports the minimum of everything it
// holds. Each input word carries an action (query, push or pop) and a value;
// each accepted word yields exactly one result word with the top entry, the
// minimum, an empty flag, the entry count and a status (ok, overflow on a push
// to a full stack, underflow on a pop from an empty one; both leave the stack
// as it was). Top and minimum read as zero when the stack is empty, and action
// code 3 behaves as a query. The entries live in a chain of STACK_DEPTH cells
// with the top always in the first cell: a push shifts every cell down by one,
// a pop shifts every cell up by one, all in the same clock. That shift sets
// the rate: one word per cycle, with the result in the output register in the
// cycle after it is accepted. The input side keeps accepting while the result
// register is empty or being drained in the same cycle, so a stalled result
// holds off only the next word. No clearing pass after reset: the entry count
// starts at zero and cells are only read below it.
module min_tracking_stack_core
    import mts_pkg::*;
#(
    parameter int STACK_DEPTH = DEF_STACK_DEPTH,
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH,
    localparam int IN_BITS    = ACTION_W + VALUE_WIDTH,
    localparam int IN_W       = ((IN_BITS + 7) / 8) * 8,
    localparam int OUT_BITS   = 2 * VALUE_WIDTH + 1 + DEPTH_FIELD_W + STATUS_W,
    localparam int OUT_W      = ((OUT_BITS + 7) / 8) * 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    // s_tdata, lowest bit up: action, value, zero pad
    input  logic [IN_W-1:0]  s_tdata,
    input  logic             s_tvalid,
    output logic             s_tready,
    // m_tdata, lowest bit up: top_value, min_value, is_empty, depth_used, status, zero pad
    output logic [OUT_W-1:0] m_tdata,
    output logic             m_tvalid,
    input  logic             m_tready
);

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(STACK_DEPTH);

    // ---------------- input unpack ----------------
    logic [ACTION_W-1:0]           in_action;
    logic signed [VALUE_WIDTH-1:0] in_value;
    logic                          in_fire;

    assign in_action = s_tdata[ACTION_W-1:0];
    assign in_value  = s_tdata[IN_BITS-1:ACTION_W];
    assign s_tready  = !m_tvalid || m_tready;
    assign in_fire   = s_tvalid && s_tready;

    // ---------------- control ----------------
    logic [CW-1:0]       count_reg, count_next;
    logic [STATUS_W-1:0] status_next;
    shift_ctrl_t         ctrl;

    logic signed [VALUE_WIDTH-1:0] cell_data [STACK_DEPTH];
    logic signed [VALUE_WIDTH-1:0] cell_min  [STACK_DEPTH];
    logic signed [VALUE_WIDTH-1:0] push_min;

    // running minimum for the new top; ties keep the one below
    always_comb begin
        if (count_reg == '0) begin
            push_min = in_value;
        end else if (in_value < cell_min[0]) begin
            push_min = in_value;
        end else begin
            push_min = cell_min[0];
        end
    end

    always_comb begin
        ctrl        = '0;
        status_next = ST_OK;
        count_next  = count_reg;
        if (in_fire) begin
            case (in_action)
                ACT_PUSH: begin
                    if (count_reg == FULL_COUNT) begin
                        status_next = ST_OVERFLOW;
                    end else begin
                        ctrl.push  = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                end
                ACT_POP: begin
                    if (count_reg == '0) begin
                        status_next = ST_UNDERFLOW;
                    end else begin
                        ctrl.pop   = 1'b1;
                        count_next = count_reg - 1'b1;
                    end
                end
                default: begin
                    // query, and the unused code that acts as one
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    // ---------------- cell chain ----------------
    for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
        logic signed [VALUE_WIDTH-1:0] up_d, up_m, dn_d, dn_m;
        if (i == 0) begin : g_head
            assign up_d = in_value;
            assign up_m = push_min;
        end else begin : g_mid
            assign up_d = cell_data[i-1];
            assign up_m = cell_min[i-1];
        end
        if (i == STACK_DEPTH - 1) begin : g_tail
            assign dn_d = '0;
            assign dn_m = '0;
        end else begin : g_body
            assign dn_d = cell_data[i+1];
            assign dn_m = cell_min[i+1];
        end
        mts_cell #(
            .VALUE_WIDTH(VALUE_WIDTH)
        ) u_cell (
            .aclk   (aclk),
            .ctrl   (ctrl),
            .up_data(up_d),
            .up_min (up_m),
            .dn_data(dn_d),
            .dn_min (dn_m),
            .data_q (cell_data[i]),
            .min_q  (cell_min[i])
        );
    end

    // ---------------- result ----------------
    // top after the op: zero if empty, else pushed word, old second cell or first cell
    logic signed [VALUE_WIDTH-1:0] top_next, min_next;
    logic                          empty_next;
    logic [CW+DEPTH_FIELD_W-1:0]   count_ext;

    always_comb begin
        empty_next = (count_next == '0);
        if (empty_next) begin
            top_next = '0;
            min_next = '0;
        end else if (ctrl.push) begin
            top_next = in_value;
            min_next = push_min;
        end else if (ctrl.pop) begin
            top_next = cell_data[1];
            min_next = cell_min[1];
        end else begin
            top_next = cell_data[0];
            min_next = cell_min[0];
        end
    end

    assign count_ext = {{DEPTH_FIELD_W{1'b0}}, count_next};

    logic                          m_valid_reg;
    logic signed [VALUE_WIDTH-1:0] m_top_reg, m_min_reg;
    logic                          m_empty_reg;
    logic [DEPTH_FIELD_W-1:0]      m_depth_reg;
    logic [STATUS_W-1:0]           m_status_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (in_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            m_top_reg    <= top_next;
            m_min_reg    <= min_next;
            m_empty_reg  <= empty_next;
            m_depth_reg  <= count_ext[DEPTH_FIELD_W-1:0];
            m_status_reg <= status_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(OUT_W - OUT_BITS){1'b0}}, m_status_reg, m_depth_reg,
                       m_empty_reg, m_min_reg, m_top_reg};

    // ---------------- assertions ----------------
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FULL_COUNT)
        else $error("entry count above stack depth");

    a_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && in_action == ACT_PUSH && count_reg == FULL_COUNT)
        |=> (m_tvalid && m_status_reg == ST_OVERFLOW && $stable(count_reg)))
        else $error("full push not flagged or stack changed");

    a_push_top: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && in_action == ACT_PUSH && count_reg != FULL_COUNT)
        |=> (m_top_reg == $past(in_value) && cell_data[0] == $past(in_value)))
        else $error("pushed word not on top");

    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_empty_reg) |-> (m_top_reg == '0 && m_min_reg == '0))
        else $error("empty result with nonzero top or minimum");

    a_min_le_top: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_empty_reg) |-> (m_min_reg <= m_top_reg))
        else $error("minimum above top entry");

endmodule
